@@ sv/best_fit_segment_space_allocator_defines.svh @@
// Assertion macros shared by the allocator's checker.
// Depends on a clk and an active-high rst in the scope of each use.
`ifndef BEST_FIT_SEGMENT_SPACE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_SEGMENT_SPACE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BFSSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfssa assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BFSSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfssa assertion failed");

// Next-cycle implication that is also checked across reset.
`define BFSSA_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bfssa assertion failed");

`endif

@@ sv/bfssa_pkg.sv @@
// Types and fixed constants of the best-fit segment space allocator.
// Has no dependencies; used by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package bfssa_pkg;

  localparam int FIELD_W = 16;
  localparam int OFS_W = 17;
  localparam logic [FIELD_W-1:0] SEG_RESET = 16'd4096;

  typedef struct packed {
    logic [FIELD_W-1:0] block_size;
    logic [FIELD_W-1:0] new_container_id;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] container_id;
    logic [FIELD_W-1:0] grant_offset;
    logic               created_new;
    logic               table_full_drop;
  } grant_t;

  typedef enum logic [9:0] {
    S_IDLE        = 10'b00_0000_0001,
    S_SRCH_RD     = 10'b00_0000_0010,
    S_SRCH_CHK    = 10'b00_0000_0100,
    S_REM_RD      = 10'b00_0000_1000,
    S_REM_WR      = 10'b00_0001_0000,
    S_SORT_KEY_RD = 10'b00_0010_0000,
    S_SORT_KEY    = 10'b00_0100_0000,
    S_SORT_CMP    = 10'b00_1000_0000,
    S_SORT_PUT    = 10'b01_0000_0000,
    S_FINISH      = 10'b10_0000_0000
  } state_t;

endpackage

@@ sv/bfssa_table.sv @@
// Entry table of the allocator: one write port and one registered read port.
// Standalone; instantiated by best_fit_segment_space_allocator.
`timescale 1ns / 1ps

module bfssa_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 33,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/best_fit_segment_space_allocator.sv @@
// Top level of the best-fit segment space allocator: sequencer and result register.
// Depends on bfssa_pkg and bfssa_table.
//
//   channel   signals                     direction  payload
//   req       req_valid / req_ready        in         bfssa_pkg::req_t
//   grant     grant_valid / grant_ready    out        bfssa_pkg::grant_t
//   cfg       cfg_we                       in         cfg_wdata (segment size)
//
// One request is handled at a time on the single-read-port table. A request not below the
// segment size goes straight to the grant; otherwise entries are read and checked in order,
// and a new entry is appended (or dropped when the table is full) if none fits. A hit removes
// its entry when it is used up, moving the later entries up, then re-sorts the entries left
// by remaining space. A grant still waiting holds the finished request.
// Reset is synchronous and empties the table; the grant register lets the next
// request in while a grant waits, and a finished request waits for it to free.
`timescale 1ns / 1ps

module best_fit_segment_space_allocator #(
  parameter int TABLE_DEPTH = 16,
  parameter int ID_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bfssa_pkg::req_t   req,
  output logic              grant_valid,
  input  logic              grant_ready,
  output bfssa_pkg::grant_t grant,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  localparam int FW = bfssa_pkg::FIELD_W;
  localparam int OW = bfssa_pkg::OFS_W;
  localparam int SW = (ID_BITS < FW) ? ID_BITS : FW;
  localparam int EW = SW + OW;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  bfssa_pkg::state_t state, state_next;
  logic [FW-1:0]    seg;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] k, k_next, i, i_next, j, j_next;
  logic [FW-1:0]    size;
  logic [SW-1:0]    nid;
  logic [EW-1:0]    key, key_next;
  bfssa_pkg::grant_t res, res_next;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [EW-1:0]    wdata, rdata;

  logic [OW-1:0]    rd_off, new_off;
  logic [SW-1:0]    rd_id;
  logic [OW:0]      need;
  logic             fits, gone, below_seg, accept;
  logic [CNT_W-1:0] k_p1, j_p1, j_m1, j_m2, i_p1, i_m1;

  bfssa_table #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req_ready = (state == bfssa_pkg::S_IDLE);
  assign accept = req_valid && req_ready;
  assign below_seg = req.block_size < seg;

  assign rd_off = rdata[OW-1:0];
  assign rd_id = rdata[EW-1:OW];
  assign need = (OW+1)'(rd_off) + (OW+1)'(size);
  assign fits = (OW+1)'(seg) >= need;
  assign new_off = rd_off + OW'(size) + OW'(1);
  assign gone = new_off >= OW'(seg);

  assign k_p1 = k + CNT_W'(1);
  assign j_p1 = j + CNT_W'(1);
  assign j_m1 = j - CNT_W'(1);
  assign j_m2 = j - CNT_W'(2);
  assign i_p1 = i + CNT_W'(1);
  assign i_m1 = i - CNT_W'(1);

  always_comb begin
    state_next = state;
    count_next = count;
    k_next = k;
    i_next = i;
    j_next = j;
    key_next = key;
    res_next = res;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      bfssa_pkg::S_IDLE: begin
        if (req_valid) begin
          res_next.container_id = FW'(req.new_container_id[SW-1:0]);
          res_next.grant_offset = '0;
          res_next.created_new = 1'b1;
          res_next.table_full_drop = 1'b0;
          k_next = '0;
          state_next = below_seg ? bfssa_pkg::S_SRCH_RD : bfssa_pkg::S_FINISH;
        end
      end
      bfssa_pkg::S_SRCH_RD: begin
        if (k < count) begin
          raddr = k[IDX_W-1:0];
          state_next = bfssa_pkg::S_SRCH_CHK;
        end else begin
          if (count < CNT_W'(TABLE_DEPTH)) begin
            we = 1'b1;
            waddr = count[IDX_W-1:0];
            wdata = {nid, OW'(size) + OW'(1)};
            count_next = count + CNT_W'(1);
          end else begin
            res_next.table_full_drop = 1'b1;
          end
          state_next = bfssa_pkg::S_FINISH;
        end
      end
      bfssa_pkg::S_SRCH_CHK: begin
        if (fits) begin
          res_next.container_id = FW'(rd_id);
          res_next.grant_offset = rd_off[FW-1:0];
          res_next.created_new = 1'b0;
          i_next = CNT_W'(1);
          if (gone) begin
            j_next = k;
            state_next = bfssa_pkg::S_REM_RD;
          end else begin
            we = 1'b1;
            waddr = k[IDX_W-1:0];
            wdata = {rd_id, new_off};
            state_next = bfssa_pkg::S_SORT_KEY_RD;
          end
        end else begin
          k_next = k_p1;
          state_next = bfssa_pkg::S_SRCH_RD;
        end
      end
      bfssa_pkg::S_REM_RD: begin
        if (j_p1 < count) begin
          raddr = j_p1[IDX_W-1:0];
          state_next = bfssa_pkg::S_REM_WR;
        end else begin
          count_next = count - CNT_W'(1);
          state_next = bfssa_pkg::S_SORT_KEY_RD;
        end
      end
      bfssa_pkg::S_REM_WR: begin
        we = 1'b1;
        waddr = j[IDX_W-1:0];
        wdata = rdata;
        j_next = j_p1;
        state_next = bfssa_pkg::S_REM_RD;
      end
      bfssa_pkg::S_SORT_KEY_RD: begin
        if (i < count) begin
          raddr = i[IDX_W-1:0];
          state_next = bfssa_pkg::S_SORT_KEY;
        end else begin
          state_next = bfssa_pkg::S_FINISH;
        end
      end
      bfssa_pkg::S_SORT_KEY: begin
        key_next = rdata;
        j_next = i;
        raddr = i_m1[IDX_W-1:0];
        state_next = bfssa_pkg::S_SORT_CMP;
      end
      bfssa_pkg::S_SORT_CMP: begin
        we = 1'b1;
        waddr = j[IDX_W-1:0];
        if (rd_off < key[OW-1:0]) begin
          wdata = rdata;
          j_next = j_m1;
          if (j == CNT_W'(1)) begin
            state_next = bfssa_pkg::S_SORT_PUT;
          end else begin
            raddr = j_m2[IDX_W-1:0];
          end
        end else begin
          wdata = key;
          i_next = i_p1;
          state_next = bfssa_pkg::S_SORT_KEY_RD;
        end
      end
      bfssa_pkg::S_SORT_PUT: begin
        we = 1'b1;
        waddr = j[IDX_W-1:0];
        wdata = key;
        i_next = i_p1;
        state_next = bfssa_pkg::S_SORT_KEY_RD;
      end
      bfssa_pkg::S_FINISH: begin
        if (!grant_valid || grant_ready) begin
          state_next = bfssa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfssa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfssa_pkg::S_IDLE;
      count <= '0;
      seg <= bfssa_pkg::SEG_RESET;
      grant_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        seg <= cfg_wdata;
      end
      if (state == bfssa_pkg::S_FINISH && (!grant_valid || grant_ready)) begin
        grant_valid <= 1'b1;
      end else if (grant_ready) begin
        grant_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    i <= i_next;
    j <= j_next;
    key <= key_next;
    res <= res_next;
    if (accept) begin
      size <= req.block_size;
      nid <= req.new_container_id[SW-1:0];
    end
    if (state == bfssa_pkg::S_FINISH && (!grant_valid || grant_ready)) begin
      grant <= res;
    end
  end

endmodule

@@ sv/bfssa_checker.sv @@
// Port-level checker for the allocator and the bind that attaches it.
// Depends on bfssa_pkg and best_fit_segment_space_allocator_defines.svh.
`timescale 1ns / 1ps
`include "best_fit_segment_space_allocator_defines.svh"

module bfssa_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              grant_valid,
  input logic              grant_ready,
  input bfssa_pkg::grant_t grant
);

  // Reset leaves no grant pending and the request side open.
  `BFSSA_ASSERT_RST(a_reset_idle, rst, !grant_valid && req_ready)

  // A request transfer keeps the request side closed in the next cycle.
  `BFSSA_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)

  // A stalled grant stays valid and unchanged.
  `BFSSA_ASSERT_NXT(a_grant_hold, grant_valid && !grant_ready, grant_valid && $stable(grant))

  // A grant into an existing container never reports a dropped append.
  `BFSSA_ASSERT_IMP(a_drop_only_new, grant_valid && grant.table_full_drop, grant.created_new)

endmodule

bind best_fit_segment_space_allocator bfssa_checker u_bfssa_checker (.*);

@@ verif/best_fit_segment_space_allocator_tb.sv @@
// Self-checking testbench for best_fit_segment_space_allocator, with a scoreboard class
// that predicts every grant from its own copy of the container table.
// Depends on bfssa_pkg and the allocator RTL.
`timescale 1ns / 1ps

class alloc_scoreboard #(int DEPTH = 16);
  logic [15:0] seg_bytes;
  logic [15:0] slot_id [DEPTH];
  logic [16:0] slot_ofs [DEPTH];
  int slot_cnt;
  bfssa_pkg::grant_t due[$];
  int failures;
  int checked;
  int reused;
  int fresh;
  int dropped;

  function new();
    seg_bytes = bfssa_pkg::SEG_RESET;
    slot_cnt = 0;
    failures = 0;
    checked = 0;
    reused = 0;
    fresh = 0;
    dropped = 0;
  endfunction

  function int room(int k);
    return int'(seg_bytes) - int'(slot_ofs[k]);
  endfunction

  function int pending();
    return due.size();
  endfunction

  function void drop_slot(int k);
    for (int j = k; j + 1 < slot_cnt; j++) begin
      slot_id[j] = slot_id[j + 1];
      slot_ofs[j] = slot_ofs[j + 1];
    end
    slot_cnt--;
  endfunction

  function void sort_by_room();
    int j;
    int sp;
    logic [15:0] id;
    logic [16:0] of;
    for (int i = 1; i < slot_cnt; i++) begin
      id = slot_id[i];
      of = slot_ofs[i];
      sp = int'(seg_bytes) - int'(of);
      j = i;
      while (j > 0 && room(j - 1) > sp) begin
        slot_id[j] = slot_id[j - 1];
        slot_ofs[j] = slot_ofs[j - 1];
        j--;
      end
      slot_id[j] = id;
      slot_ofs[j] = of;
    end
  endfunction

  function void note_request(bfssa_pkg::req_t r);
    bfssa_pkg::grant_t g;
    int hit;
    bit fits_segment;
    hit = -1;
    fits_segment = r.block_size < seg_bytes;
    g.container_id = r.new_container_id;
    g.grant_offset = '0;
    g.created_new = 1'b1;
    g.table_full_drop = 1'b0;
    if (fits_segment) begin
      for (int k = 0; k < slot_cnt; k++) begin
        if (hit < 0 && room(k) >= int'(r.block_size)) hit = k;
      end
    end
    if (hit >= 0) begin
      g.container_id = slot_id[hit];
      g.grant_offset = slot_ofs[hit][15:0];
      g.created_new = 1'b0;
      slot_ofs[hit] = slot_ofs[hit] + {1'b0, r.block_size} + 17'd1;
      if (room(hit) <= 0) drop_slot(hit);
      sort_by_room();
      reused++;
    end else begin
      fresh++;
      if (fits_segment) begin
        if (slot_cnt < DEPTH) begin
          slot_id[slot_cnt] = r.new_container_id;
          slot_ofs[slot_cnt] = {1'b0, r.block_size} + 17'd1;
          slot_cnt++;
        end else begin
          g.table_full_drop = 1'b1;
          dropped++;
        end
      end
    end
    due.insert(due.size(), g);
  endfunction

  function void check_grant(bfssa_pkg::grant_t got);
    bfssa_pkg::grant_t want;
    if (due.size() == 0) begin
      $error("grant transfer with no request outstanding: container_id %0d", got.container_id);
      failures++;
      return;
    end
    want = due.pop_front();
    checked++;
    if (got.container_id !== want.container_id) begin
      $error("container_id: expected %0d, actual %0d", want.container_id, got.container_id);
      failures++;
    end
    if (got.grant_offset !== want.grant_offset) begin
      $error("grant_offset: expected %0d, actual %0d", want.grant_offset, got.grant_offset);
      failures++;
    end
    if (got.created_new !== want.created_new) begin
      $error("created_new: expected %0d, actual %0d", want.created_new, got.created_new);
      failures++;
    end
    if (got.table_full_drop !== want.table_full_drop) begin
      $error("table_full_drop: expected %0d, actual %0d", want.table_full_drop,
             got.table_full_drop);
      failures++;
    end
  endfunction
endclass

module best_fit_segment_space_allocator_tb;

  typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_e;

  localparam int LIMIT = 3_000_000;
  localparam int N_PHASE = 8;
  localparam int PHASE_SEG [N_PHASE] = '{0, 1, 4096, 8192, 32768, 1000, 32768, 16384};
  localparam pace_e PHASE_PACE [N_PHASE] = '{PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH,
                                             PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH};
  localparam int PHASE_ITEMS [N_PHASE] = '{50, 50, 300, 300, 350, 200, 300, 250};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  bfssa_pkg::req_t req = '0;
  logic grant_valid;
  logic grant_ready = 1'b0;
  bfssa_pkg::grant_t grant;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  pace_e pace = PACE_NONE;
  int unsigned cycles = 0;
  alloc_scoreboard sb = new();

  best_fit_segment_space_allocator #(
    .TABLE_DEPTH(16),
    .ID_BITS(16)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .grant_valid(grant_valid),
    .grant_ready(grant_ready),
    .grant(grant),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int send_pct(pace_e p);
    return (p == PACE_SEND) ? 83 : (p == PACE_BOTH) ? 32 : 0;
  endfunction

  function automatic int recv_pct(pace_e p);
    return (p == PACE_RECV) ? 83 : (p == PACE_BOTH) ? 32 : 0;
  endfunction

  function automatic int pick_gap(int pct);
    int g;
    g = 0;
    while (g < 60 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  function automatic logic [15:0] pick_size(int seg);
    int roll;
    int top;
    int near;
    roll = $urandom_range(0, 99);
    top = (seg > 1) ? seg - 1 : 1;
    near = seg + int'($urandom_range(0, 6)) - 3;
    if (roll < 65) return 16'(int'($urandom_range(0, top)) >> $urandom_range(0, 8));
    if (roll < 80) return 16'((near < 0) ? 0 : (near > 65535) ? 65535 : near);
    if (roll < 92) return 16'($urandom);
    unique case ($urandom_range(0, 2))
      0: return 16'd0;
      1: return 16'd1;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
  endfunction

  function automatic bfssa_pkg::req_t mk_req(logic [15:0] size, logic [15:0] id);
    bfssa_pkg::req_t r;
    r.block_size = size;
    r.new_container_id = id;
    return r;
  endfunction

  always begin
    @(negedge clk);
    grant_ready = ($urandom_range(0, 99) >= recv_pct(pace));
    @(posedge clk);
    if (!rst && grant_valid && grant_ready) sb.check_grant(grant);
  end

  task automatic push_request(input bfssa_pkg::req_t item);
    int gap;
    gap = pick_gap(send_pct(pace));
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = item;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(item);
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_segment(input logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    sb.seg_bytes = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Zero-size and exact-fit requests, a zero-space entry, then oversized requests.
    push_request(mk_req(16'd0, 16'h0000));
    push_request(mk_req(16'd4095, 16'hFFFF));
    push_request(mk_req(16'd4095, 16'hFFFF));
    push_request(mk_req(16'd1, 16'h1234));
    push_request(mk_req(16'd0, 16'h4321));
    push_request(mk_req(16'd4096, 16'hAAAA));
    push_request(mk_req(16'd65535, 16'h5555));
    push_request(mk_req(16'h8000, 16'h0F0F));
    // Fill the table with repeated ids until an append is dropped.
    for (int i = 0; i < 17; i++) push_request(mk_req(16'd3000, 16'h00F0 + 16'(i % 4)));
    drain();

    for (int p = 0; p < N_PHASE; p++) begin
      write_segment(16'(PHASE_SEG[p]));
      pace = PHASE_PACE[p];
      for (int n = 0; n < PHASE_ITEMS[p]; n++)
        push_request(mk_req(pick_size(PHASE_SEG[p]), pick_id()));
      drain();
    end

    pace = PACE_NONE;
    repeat (250) @(posedge clk);
    $display("Checked %0d grants over %0d phases with segment sizes from 0 to 32768.",
             sb.checked, N_PHASE + 1);
    $display("Grants into existing containers: %0d, new containers: %0d, dropped appends: %0d.",
             sb.reused, sb.fresh, sb.dropped);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
